[hdl/flt_pkg.sv]
package flt_pkg;

  // field widths
  localparam int M2_W    = 24;
  localparam int CFG_W   = 20;
  localparam int CNT_W   = 2;
  localparam int OUT_W   = 32;
  localparam int ST_W    = 2;
  localparam int PROD_W  = 2 * CFG_W;    // mi*ci, ci^2, M^2
  localparam int P2_W    = 2 * PROD_W;   // (mi*ci)^2
  localparam int NUM_CH  = 3;            // channels with their own registers
  localparam int MAX_CHANNELS_DEF = 3;

  // shared shift-add multiplier: 64 x 16 per step
  localparam int MUL_W     = 64;
  localparam int DIG_W     = 16;
  localparam int MUL_STEPS = MUL_W / DIG_W;

  // restoring divider, quotient bounded to DIVLO_W bits
  localparam int DEN_W   = 104;
  localparam int DIVLO_W = 64;
  localparam int TERM_K  = 62;           // quotient bits of the width term
  localparam int T_K     = 32;           // quotient bits of one part of T
  localparam int M2_SH   = 14;           // m2 Q.16 -> Q.30 divisor alignment
  localparam int W_SH    = 16;           // Q.16 -> Q.32
  localparam int T_SH    = 52 - T_K;     // mag * 2^52 split as (mag << 20, 32 zero bits)

  // digit-by-digit square root of a Q.32 radicand
  localparam int RAD_W  = 62;
  localparam int ROOT_W = RAD_W / 2;

  localparam logic [ST_W-1:0] ST_OK   = 2'd0;
  localparam logic [ST_W-1:0] ST_SAT  = 2'd1;
  localparam logic [ST_W-1:0] ST_ZERO = 2'd2;

  // register map
  localparam int ADDR_W = 5;
  localparam logic [2:0] REG_NOMINAL_MASS  = 3'd0;
  localparam logic [2:0] REG_CHANNEL_COUNT = 3'd1;
  localparam logic [2:0] REG_COUPLING_A    = 3'd2;
  localparam logic [2:0] REG_COUPLING_B    = 3'd3;
  localparam logic [2:0] REG_COUPLING_C    = 3'd4;
  localparam logic [2:0] REG_CHAN_MASS_A   = 3'd5;
  localparam logic [2:0] REG_CHAN_MASS_B   = 3'd6;
  localparam logic [2:0] REG_CHAN_MASS_C   = 3'd7;

  localparam logic [CFG_W-1:0] RST_NOMINAL_MASS  = 20'd65536;
  localparam logic [CNT_W-1:0] RST_CHANNEL_COUNT = 2'd1;
  localparam logic [CFG_W-1:0] RST_COUPLING      = 20'd65536;
  localparam logic [CFG_W-1:0] RST_CHAN_MASS_A   = 20'd9175;
  localparam logic [CFG_W-1:0] RST_CHAN_MASS_BC  = 20'd32505;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_MM,     // M*M
    OP_P,      // mi*ci
    OP_P2,     // (mi*ci)^2
    OP_C2,     // ci*ci
    OP_DIV1,   // (mi*ci)^2 / (m2 << 14), capped
    OP_SQRT,   // sqrt|t1 - ci^2|, accumulate
    OP_NR,     // |Dr|^2
    OP_NI,     // |Di|^2 added
    OP_DIVR,   // real part of T
    OP_DIVI    // imaginary part of T
  } op_t;

  typedef struct packed {
    op_t        op;
    logic       start;
    logic       take_in;
    logic       load_out;
    logic [1:0] chan;
  } cmd_t;

  typedef struct packed {
    logic done;
    logic m2_zero;
    logic den_zero;
  } dp_st_t;

  typedef struct packed {
    logic [CFG_W-1:0] nominal_mass;
    logic [CFG_W-1:0] coupling_a;
    logic [CFG_W-1:0] coupling_b;
    logic [CFG_W-1:0] coupling_c;
    logic [CFG_W-1:0] chan_mass_a;
    logic [CFG_W-1:0] chan_mass_b;
    logic [CFG_W-1:0] chan_mass_c;
  } cfg_t;

endpackage

[hdl/flt_ctrl.sv]
module flt_ctrl #(
  parameter int MAX_CHANNELS = flt_pkg::MAX_CHANNELS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  output logic                       out_valid,
  input  logic                       out_ready,
  input  logic [flt_pkg::CNT_W-1:0]  channel_count,
  input  flt_pkg::dp_st_t            st,
  output flt_pkg::cmd_t              cmd
);
  import flt_pkg::*;

  localparam int CapCh = (MAX_CHANNELS > NUM_CH) ? NUM_CH : MAX_CHANNELS;
  localparam logic [CNT_W-1:0] CH_CAP = CNT_W'(CapCh);

  typedef enum logic [11:0] {
    S_IDLE = 12'b000000000001,
    S_MM   = 12'b000000000010,
    S_P    = 12'b000000000100,
    S_P2   = 12'b000000001000,
    S_C2   = 12'b000000010000,
    S_DIV1 = 12'b000000100000,
    S_SQRT = 12'b000001000000,
    S_NR   = 12'b000010000000,
    S_NI   = 12'b000100000000,
    S_DIVR = 12'b001000000000,
    S_DIVI = 12'b010000000000,
    S_FIN  = 12'b100000000000
  } state_t;

  state_t           state_r, state_nxt;
  logic [1:0]       chan_r, chan_nxt;
  logic             start_r, start_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0] n_eff;
  logic [CNT_W:0]   chan_inc;
  op_t              op;
  logic             take_in, load_out;

  assign n_eff    = (channel_count > CH_CAP) ? CH_CAP : channel_count;
  assign chan_inc = {1'b0, chan_r} + 1'b1;

  always_comb begin
    state_nxt = state_r;
    chan_nxt  = chan_r;
    op        = OP_NONE;
    take_in   = 1'b0;
    load_out  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          take_in   = 1'b1;
          state_nxt = S_MM;
        end
      end
      S_MM: begin
        op = OP_MM;
        if (st.done) begin
          if (st.m2_zero) begin
            state_nxt = S_FIN;
          end else if (n_eff == '0) begin
            state_nxt = S_NR;
          end else begin
            chan_nxt  = '0;
            state_nxt = S_P;
          end
        end
      end
      S_P: begin
        op = OP_P;
        if (st.done) state_nxt = S_P2;
      end
      S_P2: begin
        op = OP_P2;
        if (st.done) state_nxt = S_C2;
      end
      S_C2: begin
        op = OP_C2;
        if (st.done) state_nxt = S_DIV1;
      end
      S_DIV1: begin
        op = OP_DIV1;
        if (st.done) state_nxt = S_SQRT;
      end
      S_SQRT: begin
        op = OP_SQRT;
        if (st.done) begin
          if (chan_inc < {1'b0, n_eff}) begin
            chan_nxt  = chan_inc[1:0];
            state_nxt = S_P;
          end else begin
            state_nxt = S_NR;
          end
        end
      end
      S_NR: begin
        op = OP_NR;
        if (st.done) state_nxt = S_NI;
      end
      S_NI: begin
        op = OP_NI;
        if (st.done) state_nxt = st.den_zero ? S_FIN : S_DIVR;
      end
      S_DIVR: begin
        op = OP_DIVR;
        if (st.done) state_nxt = S_DIVI;
      end
      S_DIVI: begin
        op = OP_DIVI;
        if (st.done) state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // one start pulse on entry to every working state
  assign start_nxt = (state_nxt != state_r) && (state_nxt != S_IDLE) && (state_nxt != S_FIN);
  assign out_valid_nxt = load_out ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      chan_r      <= '0;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      chan_r      <= chan_nxt;
      start_r     <= start_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready     = (state_r == S_IDLE);
  assign out_valid    = out_valid_r;
  assign cmd.op       = op;
  assign cmd.start    = start_r;
  assign cmd.take_in  = take_in;
  assign cmd.load_out = load_out;
  assign cmd.chan     = chan_r;

endmodule

[hdl/flt_dp.sv]
module flt_dp #(
  parameter int MAX_CHANNELS = flt_pkg::MAX_CHANNELS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  flt_pkg::cmd_t                    cmd,
  input  flt_pkg::cfg_t                    cfg,
  input  logic [flt_pkg::M2_W-1:0]         in_mass_sq,
  output flt_pkg::dp_st_t                  st,
  output logic signed [flt_pkg::OUT_W-1:0] out_t_real,
  output logic signed [flt_pkg::OUT_W-1:0] out_t_imag,
  output logic [flt_pkg::ST_W-1:0]         out_status
);
  import flt_pkg::*;

  localparam int CapCh = (MAX_CHANNELS > NUM_CH) ? NUM_CH : MAX_CHANNELS;
  localparam int SUM_W = ROOT_W + $clog2(CapCh + 1);
  localparam int DR_W  = SUM_W + W_SH + 2;
  localparam int MC_W  = $clog2(MUL_STEPS);
  localparam int DC_W  = $clog2(TERM_K + 1);
  localparam int SC_W  = $clog2(ROOT_W + 1);

  // working registers
  logic [M2_W-1:0]   m2_r;
  logic [PROD_W-1:0] msq_r, p_r, c2_r;
  logic [P2_W-1:0]   p2_r;
  logic [RAD_W-1:0]  t1_r;
  logic [SUM_W-1:0]  wr_r, wi_r;
  logic [DEN_W-1:0]  nrm_r;
  logic [OUT_W-1:0]  treal_r, timag_r;
  logic              sat_r;
  logic [OUT_W-1:0]  o_real_r, o_imag_r;
  logic [ST_W-1:0]   o_status_r;

  // denominator D = M^2 - m2 - w, Q.32
  logic [DR_W-1:0] dr, adr, adi;
  logic            dr_neg;
  assign dr     = DR_W'(msq_r) - DR_W'({m2_r, {W_SH{1'b0}}}) - DR_W'({wr_r, {W_SH{1'b0}}});
  assign dr_neg = dr[DR_W-1];
  assign adr    = dr_neg ? (~dr + 1'b1) : dr;
  assign adi    = DR_W'({wi_r, {W_SH{1'b0}}});

  // channel select: a, b, then c
  logic [CFG_W-1:0] ci, mi;
  always_comb begin
    case (cmd.chan)
      2'd0: begin
        ci = cfg.coupling_a;
        mi = cfg.chan_mass_a;
      end
      2'd1: begin
        ci = cfg.coupling_b;
        mi = cfg.chan_mass_b;
      end
      default: begin
        ci = cfg.coupling_c;
        mi = cfg.chan_mass_c;
      end
    endcase
  end

  // ---------------- multiplier: acc = acc*2^16 + a * digit(b) ----------------
  logic [MUL_W-1:0]       mul_a_r, mul_b_r, mul_a_sel, mul_b_sel;
  logic [2*MUL_W-1:0]     mul_acc_r, acc_step;
  logic [MUL_W+DIG_W-1:0] pp;
  logic [MC_W-1:0]        mul_cnt_r;
  logic                   mul_busy_r, mul_go, mul_done;

  always_comb begin
    mul_a_sel = '0;
    mul_b_sel = '0;
    mul_go    = 1'b0;
    case (cmd.op) inside
      OP_MM: begin
        mul_a_sel = MUL_W'(cfg.nominal_mass);
        mul_b_sel = MUL_W'(cfg.nominal_mass);
      end
      OP_P: begin
        mul_a_sel = MUL_W'(mi);
        mul_b_sel = MUL_W'(ci);
      end
      OP_P2: begin
        mul_a_sel = MUL_W'(p_r);
        mul_b_sel = MUL_W'(p_r);
      end
      OP_C2: begin
        mul_a_sel = MUL_W'(ci);
        mul_b_sel = MUL_W'(ci);
      end
      OP_NR: begin
        mul_a_sel = MUL_W'(adr);
        mul_b_sel = MUL_W'(adr);
      end
      OP_NI: begin
        mul_a_sel = MUL_W'(adi);
        mul_b_sel = MUL_W'(adi);
      end
      default: ;
    endcase
    case (cmd.op) inside
      OP_MM, OP_P, OP_P2, OP_C2, OP_NR, OP_NI: mul_go = cmd.start;
      default: mul_go = 1'b0;
    endcase
  end

  assign pp       = mul_a_r * mul_b_r[MUL_W-1 -: DIG_W];
  assign acc_step = {mul_acc_r[2*MUL_W-DIG_W-1:0], {DIG_W{1'b0}}} + (2*MUL_W)'(pp);
  assign mul_done = mul_busy_r && (mul_cnt_r == MC_W'(MUL_STEPS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_busy_r <= 1'b0;
      mul_cnt_r  <= '0;
    end else if (mul_go) begin
      mul_busy_r <= 1'b1;
      mul_cnt_r  <= '0;
    end else if (mul_busy_r) begin
      mul_busy_r <= !mul_done;
      mul_cnt_r  <= mul_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mul_go) begin
      mul_a_r   <= mul_a_sel;
      mul_b_r   <= mul_b_sel;
      mul_acc_r <= '0;
    end else if (mul_busy_r) begin
      mul_acc_r <= acc_step;
      mul_b_r   <= mul_b_r << DIG_W;
    end
  end

  // ---------------- restoring divider, bounded quotient ----------------
  logic [DEN_W:0]     dv_rem_r, dv_r2, dv_rnew;
  logic [DEN_W-1:0]   dv_den_r, dv_hi_sel, dv_den_sel;
  logic [DIVLO_W-1:0] dv_lo_r, dv_q_r, dv_lo_sel, dv_q_step;
  logic [DC_W-1:0]    dv_cnt_r, dv_k_sel;
  logic               dv_busy_r, dv_over_r, dv_go, dv_done, dv_ge;

  always_comb begin
    dv_hi_sel  = '0;
    dv_lo_sel  = '0;
    dv_den_sel = nrm_r;
    dv_k_sel   = DC_W'(T_K);
    dv_go      = 1'b0;
    case (cmd.op)
      OP_DIV1: begin
        dv_hi_sel  = DEN_W'(p2_r >> TERM_K);
        dv_lo_sel  = {p2_r[TERM_K-1:0], {(DIVLO_W-TERM_K){1'b0}}};
        dv_den_sel = DEN_W'({m2_r, {M2_SH{1'b0}}});
        dv_k_sel   = DC_W'(TERM_K);
        dv_go      = cmd.start;
      end
      OP_DIVR: begin
        dv_hi_sel = DEN_W'({adr, {T_SH{1'b0}}});
        dv_go     = cmd.start;
      end
      OP_DIVI: begin
        dv_hi_sel = DEN_W'({adi, {T_SH{1'b0}}});
        dv_go     = cmd.start;
      end
      default: ;
    endcase
  end

  assign dv_r2     = {dv_rem_r[DEN_W-1:0], dv_lo_r[DIVLO_W-1]};
  assign dv_ge     = dv_r2 >= {1'b0, dv_den_r};
  assign dv_rnew   = dv_ge ? (dv_r2 - {1'b0, dv_den_r}) : dv_r2;
  assign dv_q_step = {dv_q_r[DIVLO_W-2:0], dv_ge};
  assign dv_done   = dv_busy_r && (dv_cnt_r == DC_W'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_busy_r <= 1'b0;
      dv_cnt_r  <= '0;
    end else if (dv_go) begin
      dv_busy_r <= 1'b1;
      dv_cnt_r  <= dv_k_sel;
    end else if (dv_busy_r) begin
      dv_busy_r <= !dv_done;
      dv_cnt_r  <= dv_cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (dv_go) begin
      dv_rem_r  <= {1'b0, dv_hi_sel};
      dv_den_r  <= dv_den_sel;
      dv_lo_r   <= dv_lo_sel;
      dv_q_r    <= '0;
      // quotient would not fit in K bits
      dv_over_r <= dv_hi_sel >= dv_den_sel;
    end else if (dv_busy_r) begin
      dv_rem_r <= dv_rnew;
      dv_lo_r  <= dv_lo_r << 1;
      dv_q_r   <= dv_q_step;
    end
  end

  // quotient to Q12.20 with clip; returns {clip, value}
  function automatic logic [OUT_W:0] to_q(input logic neg, input logic over,
                                          input logic [DIVLO_W-1:0] q);
    logic [DIVLO_W-1:0] lim;
    logic [OUT_W-1:0]   mag;
    logic               clip;
    lim  = neg ? (DIVLO_W'(1) << (OUT_W - 1)) : ((DIVLO_W'(1) << (OUT_W - 1)) - DIVLO_W'(1));
    clip = over || (q > lim);
    mag  = clip ? lim[OUT_W-1:0] : q[OUT_W-1:0];
    return {clip, neg ? (~mag + 1'b1) : mag};
  endfunction

  logic [OUT_W:0] qr, qi;
  assign qr = to_q(dr_neg, dv_over_r, dv_q_step);
  assign qi = to_q(1'b0, dv_over_r, dv_q_step);

  // ---------------- square root, two radicand bits per step ----------------
  logic [RAD_W-1:0]  sq_x_r, diff;
  logic [ROOT_W+1:0] sq_rem_r, sq_trial;
  logic [ROOT_W+3:0] sq_r2;
  logic [ROOT_W-1:0] sq_root_r, sq_root_step;
  logic [SC_W-1:0]   sq_cnt_r;
  logic              sq_busy_r, sq_real_r, sq_go, sq_done, sq_ge, t1_ge;

  assign t1_ge    = t1_r >= RAD_W'(c2_r);
  assign diff     = t1_ge ? (t1_r - RAD_W'(c2_r)) : (RAD_W'(c2_r) - t1_r);
  assign sq_go    = cmd.start && (cmd.op == OP_SQRT);
  assign sq_r2    = {sq_rem_r, sq_x_r[RAD_W-1 -: 2]};
  assign sq_trial = {sq_root_r, 2'b01};
  assign sq_ge    = sq_r2 >= (ROOT_W+4)'(sq_trial);
  assign sq_root_step = {sq_root_r[ROOT_W-2:0], sq_ge};
  assign sq_done  = sq_busy_r && (sq_cnt_r == SC_W'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_busy_r <= 1'b0;
      sq_cnt_r  <= '0;
    end else if (sq_go) begin
      sq_busy_r <= 1'b1;
      sq_cnt_r  <= SC_W'(ROOT_W);
    end else if (sq_busy_r) begin
      sq_busy_r <= !sq_done;
      sq_cnt_r  <= sq_cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (sq_go) begin
      sq_x_r    <= diff;
      sq_rem_r  <= '0;
      sq_root_r <= '0;
      sq_real_r <= t1_ge;
    end else if (sq_busy_r) begin
      sq_x_r    <= sq_x_r << 2;
      sq_rem_r  <= sq_ge ? (ROOT_W+2)'(sq_r2 - (ROOT_W+4)'(sq_trial)) : (ROOT_W+2)'(sq_r2);
      sq_root_r <= sq_root_step;
    end
  end

  // ---------------- result registers ----------------
  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      m2_r  <= in_mass_sq;
      wr_r  <= '0;
      wi_r  <= '0;
      sat_r <= 1'b0;
    end
    if (mul_done) begin
      case (cmd.op)
        OP_MM:   msq_r <= acc_step[PROD_W-1:0];
        OP_P:    p_r   <= acc_step[PROD_W-1:0];
        OP_P2:   p2_r  <= acc_step[P2_W-1:0];
        OP_C2:   c2_r  <= acc_step[PROD_W-1:0];
        OP_NR:   nrm_r <= acc_step[DEN_W-1:0];
        OP_NI:   nrm_r <= nrm_r + acc_step[DEN_W-1:0];
        default: ;
      endcase
    end
    if (dv_done) begin
      case (cmd.op)
        OP_DIV1: t1_r <= dv_over_r ? {RAD_W{1'b1}} : dv_q_step[RAD_W-1:0];
        OP_DIVR: begin
          treal_r <= qr[OUT_W-1:0];
          if (qr[OUT_W]) sat_r <= 1'b1;
        end
        OP_DIVI: begin
          timag_r <= qi[OUT_W-1:0];
          if (qi[OUT_W]) sat_r <= 1'b1;
        end
        default: ;
      endcase
    end
    if (sq_done) begin
      if (sq_real_r) wr_r <= wr_r + SUM_W'(sq_root_step);
      else           wi_r <= wi_r + SUM_W'(sq_root_step);
    end
    if (cmd.load_out) begin
      if (st.m2_zero || st.den_zero) begin
        o_real_r   <= '0;
        o_imag_r   <= '0;
        o_status_r <= ST_ZERO;
      end else begin
        o_real_r   <= treal_r;
        o_imag_r   <= timag_r;
        o_status_r <= sat_r ? ST_SAT : ST_OK;
      end
    end
  end

  assign st.done     = mul_done || dv_done || sq_done;
  assign st.m2_zero  = (m2_r == '0);
  assign st.den_zero = (dr == '0) && (wi_r == '0);

  assign out_t_real = $signed(o_real_r);
  assign out_t_imag = $signed(o_imag_r);
  assign out_status = o_status_r;

endmodule

[hdl/flatte_lineshape_eval.sv]
// Flatte amplitude T = 1/(M^2 - m2 - w) for one m2 per item, one item at a time.
// Steps: M^2, then per active channel three multiplies, the 62-step divide and the 31-step
//   root; then |D|^2 and the two 32-step divides of T. A zero m2 ends the item after M^2,
//   a zero denominator after |D|^2. One multiplier, divider, root unit.
// A new item is taken while the last result waits.
// Reset: synchronous active-low rst_n clears control and loads register reset values.
module flatte_lineshape_eval #(
  parameter int MAX_CHANNELS = flt_pkg::MAX_CHANNELS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // item in
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [flt_pkg::M2_W-1:0]         in_mass_sq,
  // result out
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [flt_pkg::OUT_W-1:0] out_t_real,
  output logic signed [flt_pkg::OUT_W-1:0] out_t_imag,
  output logic [flt_pkg::ST_W-1:0]         out_status,
  // register port
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [flt_pkg::ADDR_W-1:0]       cfg_paddr,
  input  logic [31:0]                      cfg_pwdata,
  output logic [31:0]                      cfg_prdata,
  output logic                             cfg_pready
);
  import flt_pkg::*;

  // Configuration registers, written in the APB access phase.
  cfg_t             cfg_r;
  logic [CNT_W-1:0] channel_count_r;
  logic [2:0]       reg_idx;
  logic             wr_en;

  assign reg_idx    = cfg_paddr[ADDR_W-1:2];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.nominal_mass <= RST_NOMINAL_MASS;
      channel_count_r    <= RST_CHANNEL_COUNT;
      cfg_r.coupling_a   <= RST_COUPLING;
      cfg_r.coupling_b   <= RST_COUPLING;
      cfg_r.coupling_c   <= RST_COUPLING;
      cfg_r.chan_mass_a  <= RST_CHAN_MASS_A;
      cfg_r.chan_mass_b  <= RST_CHAN_MASS_BC;
      cfg_r.chan_mass_c  <= RST_CHAN_MASS_BC;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_NOMINAL_MASS:  cfg_r.nominal_mass <= cfg_pwdata[CFG_W-1:0];
        REG_CHANNEL_COUNT: channel_count_r    <= cfg_pwdata[CNT_W-1:0];
        REG_COUPLING_A:    cfg_r.coupling_a   <= cfg_pwdata[CFG_W-1:0];
        REG_COUPLING_B:    cfg_r.coupling_b   <= cfg_pwdata[CFG_W-1:0];
        REG_COUPLING_C:    cfg_r.coupling_c   <= cfg_pwdata[CFG_W-1:0];
        REG_CHAN_MASS_A:   cfg_r.chan_mass_a  <= cfg_pwdata[CFG_W-1:0];
        REG_CHAN_MASS_B:   cfg_r.chan_mass_b  <= cfg_pwdata[CFG_W-1:0];
        REG_CHAN_MASS_C:   cfg_r.chan_mass_c  <= cfg_pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // readback
  always_comb begin
    unique case (reg_idx)
      REG_NOMINAL_MASS:  cfg_prdata = 32'(cfg_r.nominal_mass);
      REG_CHANNEL_COUNT: cfg_prdata = 32'(channel_count_r);
      REG_COUPLING_A:    cfg_prdata = 32'(cfg_r.coupling_a);
      REG_COUPLING_B:    cfg_prdata = 32'(cfg_r.coupling_b);
      REG_COUPLING_C:    cfg_prdata = 32'(cfg_r.coupling_c);
      REG_CHAN_MASS_A:   cfg_prdata = 32'(cfg_r.chan_mass_a);
      REG_CHAN_MASS_B:   cfg_prdata = 32'(cfg_r.chan_mass_b);
      REG_CHAN_MASS_C:   cfg_prdata = 32'(cfg_r.chan_mass_c);
      default:           cfg_prdata = '0;
    endcase
  end

  // Controller steps each item through: M^2, then per channel mi*ci, (mi*ci)^2,
  // ci^2, the capped divide by m2 and the root; then |D|^2 and the two divides for T.
  cmd_t   cmd;
  dp_st_t st;

  flt_ctrl #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .channel_count (channel_count_r),
    .st            (st),
    .cmd           (cmd)
  );

  // Datapath holds the shared units and the output register, so the result
  // sits there while the next item is already being worked on.
  flt_dp #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .cfg        (cfg_r),
    .in_mass_sq (in_mass_sq),
    .st         (st),
    .out_t_real (out_t_real),
    .out_t_imag (out_t_imag),
    .out_status (out_status)
  );

endmodule

[verif/tb_flatte_lineshape_eval.sv]
module tb_flatte_lineshape_eval;
  import flt_pkg::*;

  // Arithmetic limits of the Flatte evaluation
  localparam longint unsigned TERM_LIMIT = (64'd1 << 62) - 64'd1;
  localparam int N_RANDOM = 700;
  localparam int IDLE_PCT = 27;

  typedef struct {
    logic signed [OUT_W-1:0] t_real;
    logic signed [OUT_W-1:0] t_imag;
    logic [ST_W-1:0]         status;
  } amp_t;

  // Scoreboard: holds the amplitudes still owed by the block, in order.
  class amp_scoreboard;
    amp_t pending[$];
    int   n_errors;
    int   n_checked;

    function void note_item(amp_t a);
      pending = {pending, a};
    endfunction

    task check_result(amp_t got);
      amp_t exp_a;
      if (pending.size() == 0) begin
        report_mismatch("result with nothing pending", 0, got.t_real);
        return;
      end
      exp_a = pending.pop_front();
      n_checked++;
      if (got.t_real !== exp_a.t_real)
        report_mismatch("t_real", exp_a.t_real, got.t_real);
      if (got.t_imag !== exp_a.t_imag)
        report_mismatch("t_imag", exp_a.t_imag, got.t_imag);
      if (got.status !== exp_a.status)
        report_mismatch("status", exp_a.status, got.status);
    endtask

    task report_mismatch(string what, longint e, longint g);
      n_errors++;
      $display("MISMATCH %s: expected %0d got %0d", what, e, g);
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [M2_W-1:0] in_mass_sq = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [OUT_W-1:0] out_t_real, out_t_imag;
  logic [ST_W-1:0] out_status;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [ADDR_W-1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  // Predictor's copy of the register file
  logic [CFG_W-1:0] r_mass;
  logic [CNT_W-1:0] r_count;
  logic [CFG_W-1:0] r_coup[3];
  logic [CFG_W-1:0] r_cmass[3];

  amp_scoreboard sb;
  bit no_idle;       // stretch with no random idling on either side
  int n_sent;

  always #2 clk = ~clk;

  flatte_lineshape_eval u_dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_mass_sq,
    .out_valid, .out_ready, .out_t_real, .out_t_imag, .out_status,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata,
    .cfg_prdata, .cfg_pready
  );

  // Floor integer square root, bit by bit.
  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // value * 2^52 / norm, truncated toward zero, clipped to Q12.20.
  function automatic logic [31:0] part_q1220(logic signed [63:0] value,
                                             logic [127:0] norm, ref bit sat);
    logic [63:0]  mag, lim;
    logic [127:0] quo;
    mag = value[63] ? -value : value;
    lim = value[63] ? 64'h8000_0000 : 64'h7FFF_FFFF;
    quo = ({64'd0, mag} << 52) / norm;
    if (quo > {64'd0, lim}) begin
      sat = 1'b1;
      mag = lim;
    end else begin
      mag = quo[63:0];
    end
    return value[63] ? -mag[31:0] : mag[31:0];
  endfunction

  // Flatte amplitude for one m2 under the current register settings.
  function automatic amp_t flatte_amp(logic [M2_W-1:0] m2);
    amp_t a;
    int nch;
    longint unsigned wr, wi, t1, c2;
    logic [63:0] p;
    logic [127:0] q, nrm;
    logic signed [63:0] dr, di, adr, adi;
    bit sat;
    a.t_real = '0;
    a.t_imag = '0;
    a.status = ST_ZERO;
    wr = 0;
    wi = 0;
    sat = 0;
    if (m2 == 0) return a;
    nch = (r_count > 3) ? 3 : r_count;
    for (int i = 0; i < nch; i++) begin
      p = 64'(r_cmass[i]) * 64'(r_coup[i]);
      c2 = 64'(r_coup[i]) * 64'(r_coup[i]);
      q = (128'(p) * 128'(p)) / (128'(m2) << 14);
      t1 = (q > 128'(TERM_LIMIT)) ? TERM_LIMIT : q[63:0];
      if (t1 >= c2) wr += int_sqrt(t1 - c2);
      else wi += int_sqrt(c2 - t1);
    end
    dr = $signed(64'(r_mass) * 64'(r_mass)) - $signed(64'(m2) << 16)
         - $signed(wr << 16);
    di = -$signed(wi << 16);
    if (dr == 0 && di == 0) return a;
    adr = dr[63] ? -dr : dr;
    adi = di[63] ? -di : di;
    nrm = 128'(adr) * 128'(adr) + 128'(adi) * 128'(adi);
    a.t_real = part_q1220(dr, nrm, sat);
    a.t_imag = part_q1220(-di, nrm, sat);
    a.status = sat ? ST_SAT : ST_OK;
    return a;
  endfunction

  function automatic bit idle_now();
    return !no_idle && ($urandom_range(99) < IDLE_PCT);
  endfunction

  // APB write: setup then access; pready is always high.
  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= ADDR_W'({idx, 2'b00});
    cfg_pwdata <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (idx)
      REG_NOMINAL_MASS:  r_mass = val[CFG_W-1:0];
      REG_CHANNEL_COUNT: r_count = val[CNT_W-1:0];
      REG_COUPLING_A:    r_coup[0] = val[CFG_W-1:0];
      REG_COUPLING_B:    r_coup[1] = val[CFG_W-1:0];
      REG_COUPLING_C:    r_coup[2] = val[CFG_W-1:0];
      REG_CHAN_MASS_A:   r_cmass[0] = val[CFG_W-1:0];
      REG_CHAN_MASS_B:   r_cmass[1] = val[CFG_W-1:0];
      REG_CHAN_MASS_C:   r_cmass[2] = val[CFG_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_setting(logic [CFG_W-1:0] m, logic [1:0] n,
                              logic [CFG_W-1:0] ca, logic [CFG_W-1:0] cb,
                              logic [CFG_W-1:0] cc, logic [CFG_W-1:0] ma,
                              logic [CFG_W-1:0] mb, logic [CFG_W-1:0] mc);
    reg_write(REG_NOMINAL_MASS, m);
    reg_write(REG_CHANNEL_COUNT, n);
    reg_write(REG_COUPLING_A, ca);
    reg_write(REG_COUPLING_B, cb);
    reg_write(REG_COUPLING_C, cc);
    reg_write(REG_CHAN_MASS_A, ma);
    reg_write(REG_CHAN_MASS_B, mb);
    reg_write(REG_CHAN_MASS_C, mc);
  endtask

  // Send one m2; valid holds until accepted, gaps drawn at random.
  // Starts on a fresh falling edge so valid is never driven twice in one step.
  task automatic send_mass(logic [M2_W-1:0] m2);
    @(negedge clk);
    while (idle_now()) @(negedge clk);
    in_valid <= 1'b1;
    in_mass_sq <= m2;
    sb.note_item(flatte_amp(m2));
    do @(posedge clk); while (!in_ready);
    n_sent++;
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Wait for every pending amplitude, then the block's drain time.
  task automatic drain();
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (500) @(negedge clk);
  endtask

  // Result side: ready toggles at random but for the no-idle stretch; check at each accepting edge.
  always @(negedge clk) out_ready <= no_idle ? 1'b1 : !idle_now();

  always @(posedge clk) begin
    amp_t got;
    if (rst_n && out_valid && out_ready) begin
      got.t_real = out_t_real;
      got.t_imag = out_t_imag;
      got.status = out_status;
      sb.check_result(got);
    end
  end

  function automatic logic [M2_W-1:0] rand_m2();
    // mostly near the resonance region, some extremes and whole-range values
    case ($urandom_range(9))
      0: return M2_W'($urandom_range(255));
      1: return M2_W'($urandom);
      2: return {M2_W{1'b1}} - M2_W'($urandom_range(15));
      default: return M2_W'($urandom_range(32'h0004_0000, 32'h0000_4000));
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] rand_cfg();
    case ($urandom_range(5))
      0: return CFG_W'(1);
      1: return {CFG_W{1'b1}};
      2: return CFG_W'($urandom);
      default: return CFG_W'($urandom_range(32'h0002_0000, 32'h0000_1000));
    endcase
  endfunction

  initial begin
    sb = new();
    no_idle = 0;
    n_sent = 0;
    r_mass = RST_NOMINAL_MASS;
    r_count = RST_CHANNEL_COUNT;
    r_coup = '{RST_COUPLING, RST_COUPLING, RST_COUPLING};
    r_cmass = '{RST_CHAN_MASS_A, RST_CHAN_MASS_BC, RST_CHAN_MASS_BC};
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // Directed, reset settings: zero m2, extremes, one bit at a time
    send_mass('0);
    send_mass(M2_W'(1));
    send_mass({M2_W{1'b1}});
    send_mass(M2_W'(65536));      // m2 equals M^2 region
    send_mass(M2_W'(20000));
    for (int b = 0; b < M2_W; b += 4) send_mass(M2_W'(1) << b);
    drain();

    // No channels: m2 = M^2 gives a zero denominator
    load_setting(20'd65536, 2'd0, 20'd1, 20'd1, 20'd1, 20'd1, 20'd1, 20'd1);
    send_mass(M2_W'(65536));
    send_mass(M2_W'(65537));
    send_mass(M2_W'(65535));      // tiny denominator, saturates
    drain();

    // All fields at their top, three channels, then zero couplings
    load_setting({CFG_W{1'b1}}, 2'd3, {CFG_W{1'b1}}, {CFG_W{1'b1}},
                 {CFG_W{1'b1}}, {CFG_W{1'b1}}, {CFG_W{1'b1}}, {CFG_W{1'b1}});
    send_mass(M2_W'(1));
    send_mass({M2_W{1'b1}});
    send_mass(M2_W'(12345));
    drain();
    load_setting(20'd1, 2'd3, 20'd0, 20'd0, 20'd0, 20'd1, 20'd1, 20'd1);
    send_mass(M2_W'(1));
    send_mass(M2_W'(99));
    drain();

    // Random phases: new register setting, then a burst of m2 values
    for (int ph = 0; ph < 14; ph++) begin
      load_setting(rand_cfg(), 2'($urandom_range(3)), rand_cfg(), rand_cfg(),
                   rand_cfg(), rand_cfg(), rand_cfg(), rand_cfg());
      no_idle = (ph == 5);
      for (int k = 0; k < N_RANDOM / 14; k++) begin
        send_mass(rand_m2());
        // hold the sender until the block has caught up
        if (k == 10) while (sb.pending.size() != 0) @(negedge clk);
      end
      drain();
    end
    no_idle = 0;

    $display("covered %0d m2 values over 18 register settings, %0d amplitudes checked",
             n_sent, sb.n_checked);
    $display("including zero m2, zero denominator, saturation and 0..3 channels");
    if (sb.n_errors == 0 && sb.pending.size() == 0)
      $display("tb_flatte_lineshape_eval OK");
    else
      $display("tb_flatte_lineshape_eval NOT OK");
    $finish;
  end

  // Watchdog: reports NOT OK and stops if the ~720 items and their drains overrun its limit.
  initial begin
    #10000000;
    $display("tb_flatte_lineshape_eval NOT OK");
    $finish;
  end

endmodule
